### rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, constants and helpers for the k-way merge min-heap block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int KEY_BITS      = 32;
    localparam int SRC_BITS      = 4;
    localparam int FUNC_BITS     = 2;
    localparam int CFG_BITS      = 5;
    localparam int DEF_MAX_LISTS = 16;
    localparam int RST_NUM_LISTS = 2;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_NEXT    = 2'd1,
        FUNC_EXHAUST = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0]       func;
        logic signed [KEY_BITS-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] min_key;
        logic [SRC_BITS-1:0]        source;
        logic                       all_done;
    } out_word_t;

    typedef struct packed {
        logic                       exhausted;
        logic [SRC_BITS-1:0]        source;
        logic signed [KEY_BITS-1:0] key;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_LD,
        ST_LEFT,
        ST_RIGHT,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic build_start;
        logic replace;
        logic rd_build;
        logic take_e;
        logic rd_left;
        logic rd_right;
        logic take_left;
        logic wr_e;
        logic move;
        logic build_next;
        logic set_ready;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic ld_ok;
        logic ld_last;
        logic rep_ok;
        logic root_done;
        logic left_ok;
        logic child_wins;
        logic build_last;
        logic out_free;
    } status_t;

    // exhausted entries rank above every key
    function automatic logic entry_less(entry_t a, entry_t b);
        logic r;
        if (a.exhausted)
            r = 1'b0;
        else if (b.exhausted)
            r = 1'b1;
        else
            r = ($signed(a.key) < $signed(b.key));
        return r;
    endfunction

endpackage

### rtl/core/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap storage, sift registers, load/build counters and the result register.
// ----------------------------------------------------------------------------
module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS = DEF_MAX_LISTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  in_word_t            in_word,
    input  logic                out_ready,
    output logic                out_valid,
    output out_word_t           out_word,
    input  cmd_t                cmd,
    output status_t             status
);

    localparam int IDX_W = $clog2(MAX_LISTS);
    localparam int CNT_W = $clog2(MAX_LISTS + 1);
    localparam int CH_W  = IDX_W + 2;

    logic [CNT_W-1:0] num_lists_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic             heap_ready_reg;
    logic [IDX_W-1:0] build_idx_reg;
    logic [IDX_W-1:0] pos_reg;
    entry_t           e_reg;
    entry_t           best_reg;
    logic             lsel_reg;
    entry_t           root_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic [CH_W-1:0]  left_idx;
    logic [CH_W-1:0]  right_idx;
    logic             right_ok;
    logic             lsel;
    logic             rsel;
    entry_t           child;
    logic [IDX_W-1:0] child_idx;
    entry_t           load_entry;
    entry_t           rep_entry;
    logic [CNT_W:0]   loaded_inc;
    logic [CNT_W-1:0] cfg_lists;

    kwm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_LISTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + CH_W'(1);
    assign right_ok   = right_idx < CH_W'(num_lists_reg);
    assign lsel       = entry_less(ram_rdata, e_reg);
    assign rsel       = right_ok && entry_less(ram_rdata, best_reg);
    assign child      = rsel ? ram_rdata : best_reg;
    assign child_idx  = rsel ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
    assign loaded_inc = {1'b0, loaded_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        load_entry.exhausted = 1'b0;
        load_entry.source    = SRC_BITS'(loaded_reg);
        load_entry.key       = in_word.key;
        rep_entry.exhausted  = (in_word.func == FUNC_EXHAUST);
        rep_entry.source     = root_reg.source;
        rep_entry.key        = (in_word.func == FUNC_NEXT) ? in_word.key : root_reg.key;
    end

    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_lists = CNT_W'(1);
        else if (int'(cfg_wdata) > MAX_LISTS)
            cfg_lists = CNT_W'(MAX_LISTS);
        else
            cfg_lists = CNT_W'(cfg_wdata);
    end

    always_comb
    begin
        ram_we    = cmd.load || cmd.wr_e || cmd.move;
        ram_waddr = pos_reg;
        ram_wdata = e_reg;
        if (cmd.load)
        begin
            ram_waddr = loaded_reg[IDX_W-1:0];
            ram_wdata = load_entry;
        end
        else if (cmd.move)
        begin
            ram_wdata = child;
        end
        ram_raddr = build_idx_reg;
        if (cmd.rd_left)
            ram_raddr = left_idx[IDX_W-1:0];
        else if (cmd.rd_right)
            ram_raddr = right_idx[IDX_W-1:0];
    end

    always_comb
    begin
        status.ld_ok      = (in_word.func == FUNC_LOAD) && !heap_ready_reg
                            && (loaded_reg < num_lists_reg);
        status.ld_last    = (loaded_inc == {1'b0, num_lists_reg});
        status.rep_ok     = heap_ready_reg && !root_reg.exhausted
                            && ((in_word.func == FUNC_NEXT) || (in_word.func == FUNC_EXHAUST));
        status.root_done  = heap_ready_reg && root_reg.exhausted
                            && ((in_word.func == FUNC_NEXT) || (in_word.func == FUNC_EXHAUST));
        status.left_ok    = left_idx < CH_W'(num_lists_reg);
        status.child_wins = lsel_reg || rsel;
        status.build_last = (build_idx_reg == '0);
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lists_reg  <= CNT_W'(RST_NUM_LISTS);
            loaded_reg     <= '0;
            heap_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_lists_reg  <= cfg_lists;
                loaded_reg     <= '0;
                heap_ready_reg <= 1'b0;
            end
            else
            begin
                if (cmd.load)
                    loaded_reg <= loaded_inc[CNT_W-1:0];
                if (cmd.set_ready)
                    heap_ready_reg <= 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_start)
            build_idx_reg <= IDX_W'(num_lists_reg >> 1);
        else if (cmd.build_next)
            build_idx_reg <= build_idx_reg - IDX_W'(1);

        if (cmd.replace)
        begin
            e_reg   <= rep_entry;
            pos_reg <= '0;
        end
        else if (cmd.take_e)
        begin
            e_reg   <= ram_rdata;
            pos_reg <= build_idx_reg;
        end
        else if (cmd.move)
        begin
            pos_reg <= child_idx;
        end

        if (cmd.take_left)
        begin
            lsel_reg <= lsel;
            best_reg <= lsel ? ram_rdata : e_reg;
        end

        if (ram_we && (ram_waddr == '0))
            root_reg <= ram_wdata;

        if (cmd.emit)
        begin
            out_word_reg.all_done <= root_reg.exhausted;
            out_word_reg.min_key  <= root_reg.exhausted ? '0 : root_reg.key;
            out_word_reg.source   <= root_reg.exhausted ? '0 : root_reg.source;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= num_lists_reg)
        else $error("load count above list count");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        heap_ready_reg |-> (loaded_reg == num_lists_reg))
        else $error("heap ready with lists missing");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_e || cmd.move) |-> ({1'b0, pos_reg} < CH_W'(num_lists_reg)))
        else $error("sift write outside heap");

endmodule

### rtl/core/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for load, heap build, root replace, sift-down and result issue.
// ----------------------------------------------------------------------------
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   building_reg;
    logic   building_next;
    logic   accept;
    logic   sift_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign sift_end = ((state_reg == ST_LEFT) && !status.left_ok)
                      || ((state_reg == ST_CMP) && !status.child_wins);

    always_comb
    begin
        state_next    = state_reg;
        building_next = building_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.ld_ok && status.ld_last)
                    begin
                        state_next    = ST_BUILD_RD;
                        building_next = 1'b1;
                    end
                    else if (status.rep_ok)
                        state_next = ST_LEFT;
                    else if (status.root_done)
                        state_next = ST_EMIT;
                end
            end
            ST_BUILD_RD: state_next = ST_BUILD_LD;
            ST_BUILD_LD: state_next = ST_LEFT;
            ST_LEFT:     state_next = status.left_ok ? ST_RIGHT : ST_LEFT;
            ST_RIGHT:    state_next = ST_CMP;
            ST_CMP:      state_next = ST_LEFT;
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
        if (sift_end)
        begin
            if (building_reg && !status.build_last)
                state_next = ST_BUILD_RD;
            else
            begin
                state_next    = ST_EMIT;
                building_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load        = accept && status.ld_ok;
                cmd.build_start = accept && status.ld_ok && status.ld_last;
                cmd.replace     = accept && status.rep_ok;
            end
            ST_BUILD_RD: cmd.rd_build = 1'b1;
            ST_BUILD_LD: cmd.take_e   = 1'b1;
            ST_LEFT:
            begin
                cmd.rd_left = status.left_ok;
                cmd.wr_e    = !status.left_ok;
            end
            ST_RIGHT:
            begin
                cmd.rd_right  = 1'b1;
                cmd.take_left = 1'b1;
            end
            ST_CMP:
            begin
                cmd.move = status.child_wins;
                cmd.wr_e = !status.child_wins;
            end
            ST_EMIT:     cmd.emit = status.out_free;
            default:     cmd = '0;
        endcase
        cmd.build_next = sift_end && building_reg && !status.build_last;
        cmd.set_ready  = sift_end && building_reg && status.build_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            building_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            building_reg <= building_next;
        end
    end

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.wr_e, cmd.move}))
        else $error("two heap writes in one cycle");

    a_build_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !building_reg)
        else $error("idle with build pending");

    a_ready_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_ready |=> (state_reg == ST_EMIT))
        else $error("heap built without result");

endmodule

### rtl/core/k_way_merge_min_heap.sv
// ----------------------------------------------------------------------------
// k_way_merge_min_heap
// K-way merge of sorted signed key streams through a binary min-heap.
// ----------------------------------------------------------------------------
// channel | signals                  | dir | word
// in      | in_valid/in_ready        | in  | in_word  (func, key)
// out     | out_valid/out_ready      | out | out_word (min_key, source, all_done)
// cfg     | cfg_we/cfg_wdata         | in  | num_lists, written at once
//
// A load that is not the last is taken in IDLE. A replace walks one heap level
// per pass through LEFT, RIGHT and CMP; the single RAM read port sets this. The
// last load builds the heap: n/2+1 sift-downs, each a read via BUILD_RD and
// BUILD_LD plus the walk. Reset clears control only; no clearing pass. A result
// waiting at the output holds the next result in EMIT and blocks input accept.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS = DEF_MAX_LISTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_word
);

    cmd_t    cmd;
    status_t status;

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kwm_datapath #(
        .MAX_LISTS (MAX_LISTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (in_word),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
